>>> design/oriented_box_overlap_test_macros.svh
// Assertion macros shared by the checker
`ifndef ORIENTED_BOX_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_MACROS_SVH
// Implication check, reset-disabled.
`define OBOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication check, reset-disabled.
`define OBOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> design/obot_pkg.sv
// ----------------------------------------------------------------------------
// obot_pkg
// Shared constants and types for the oriented box overlap test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package obot_pkg;
	localparam int COORD_WIDTH_DEF    = 24;
	localparam int AXIS_FRAC_BITS_DEF = 14;
	// Width of every internal accumulator; wide enough for all exact sums.
	localparam int ACC_WIDTH = 72;

	// Multiply request from the sequencer to the serial multiplier.
	typedef struct packed {
		logic start;
	} mul_ctl_t;
endpackage
`default_nettype wire

>>> design/oriented_box_overlap_test.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_test
// Separating-axis overlap test of two oriented 2D boxes with hit point.
// ----------------------------------------------------------------------------
// Usage: send a box on s_axis with tuser = 0 to hold it (no result). A box
// with tuser = 1 is tested against the held box; one result item follows on
// m_axis: tdata = {hit_y, hit_x, hit}.
// A store item is held and the next item can follow at once. A test runs
// up to 40 products (32 for the four axes, 8 for the bounds) on one
// bit-serial multiplier, then m_axis_tvalid rises with the result; a
// separating axis ends the test at the end of that axis.
// One item is in work at a time: s_axis_tready is low from acceptance of a
// test item until its result is taken.
// Reset clears the held box to all zero and empties the output.
// A stalled m_axis_tready holds the result and the block takes no new item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module oriented_box_overlap_test #(
	parameter int COORD_WIDTH    = obot_pkg::COORD_WIDTH_DEF,
	parameter int AXIS_FRAC_BITS = obot_pkg::AXIS_FRAC_BITS_DEF,
	localparam int AXW = AXIS_FRAC_BITS + 2,
	localparam int IW  = 2 * COORD_WIDTH + 4 * AXW + 2 * (COORD_WIDTH - 1),
	localparam int IDW = ((IW + 7) / 8) * 8,
	localparam int OW  = 1 + 2 * COORD_WIDTH,
	localparam int ODW = ((OW + 7) / 8) * 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_axis_tvalid,
	output logic            s_axis_tready,
	// center_x, center_y, axis_u_x, axis_u_y, axis_v_x, axis_v_y, half_u, half_v
	input  wire [IDW-1:0]   s_axis_tdata,
	// second_box
	input  wire             s_axis_tuser,
	output logic            m_axis_tvalid,
	input  wire             m_axis_tready,
	// hit, hit_x, hit_y
	output logic [ODW-1:0]  m_axis_tdata
);
	localparam int CW = COORD_WIDTH;
	logic hit;
	logic [CW-1:0] hit_x, hit_y;

	obot_seq #(.COORD_WIDTH(CW), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cx(s_axis_tdata[CW-1:0]),
		.cy(s_axis_tdata[2*CW-1:CW]),
		.ux(s_axis_tdata[2*CW+AXW-1:2*CW]),
		.uy(s_axis_tdata[2*CW+2*AXW-1:2*CW+AXW]),
		.vx(s_axis_tdata[2*CW+3*AXW-1:2*CW+2*AXW]),
		.vy(s_axis_tdata[2*CW+4*AXW-1:2*CW+3*AXW]),
		.hu(s_axis_tdata[3*CW+4*AXW-2:2*CW+4*AXW]),
		.hv(s_axis_tdata[IW-1:3*CW+4*AXW-1]),
		.second(s_axis_tuser),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y)
	);

	assign m_axis_tdata = ODW'({hit_y, hit_x, hit});
endmodule
`default_nettype wire

>>> design/obot_serial_mul.sv
// ----------------------------------------------------------------------------
// obot_serial_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obot_serial_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire obot_pkg::mul_ctl_t         ctl,
	input  wire logic signed [AW-1:0]       a,
	input  wire logic signed [BW-1:0]       b,
	output logic                            done,
	output logic signed [obot_pkg::ACC_WIDTH-1:0] prod
);
	localparam int CW = $clog2(BW + 1);
	logic signed [obot_pkg::ACC_WIDTH-1:0] acc_q, mcand_q;
	logic [BW-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Two's complement multiplier: top bit weight is negative.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q    <= '0;
			mcand_q  <= obot_pkg::ACC_WIDTH'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (cnt_q == CW'(BW - 1))
					acc_q <= acc_q - mcand_q;
				else
					acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

>>> design/obot_seq.sv
// ----------------------------------------------------------------------------
// obot_seq
// Sequencer: holds the stored box, steps products through the serial
// multiplier, accumulates the axis tests, bounds and hit point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obot_seq #(
	parameter int COORD_WIDTH    = obot_pkg::COORD_WIDTH_DEF,
	parameter int AXIS_FRAC_BITS = obot_pkg::AXIS_FRAC_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire logic [COORD_WIDTH-1:0]   cx,
	input  wire logic [COORD_WIDTH-1:0]   cy,
	input  wire logic [AXIS_FRAC_BITS+1:0] ux,
	input  wire logic [AXIS_FRAC_BITS+1:0] uy,
	input  wire logic [AXIS_FRAC_BITS+1:0] vx,
	input  wire logic [AXIS_FRAC_BITS+1:0] vy,
	input  wire logic [COORD_WIDTH-2:0]   hu,
	input  wire logic [COORD_WIDTH-2:0]   hv,
	input  wire                           second,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          hit,
	output logic [COORD_WIDTH-1:0]        hit_x,
	output logic [COORD_WIDTH-1:0]        hit_y
);
	localparam int AXW = AXIS_FRAC_BITS + 2;
	localparam int OW  = COORD_WIDTH + 1;  // operand width incl. difference
	localparam int ACW = obot_pkg::ACC_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_WAIT, ST_AXEND, ST_BND, ST_BNDEND, ST_MID, ST_OUT
	} state_t;

	state_t state_q;
	// index 0: held, 1: new
	logic signed [COORD_WIDTH-1:0] c_q   [2][2];
	logic signed [AXW-1:0]         ax_q  [2][4];  // ux uy vx vy
	logic        [COORD_WIDTH-2:0] h_q   [2][2];
	logic signed [OW-1:0]          dx_q, dy_q;
	logic [1:0]  axis_q;   // which axis under test
	logic [3:0]  step_q;   // product index within an axis
	logic signed [ACW-1:0] cen_q, dot_q, proj_q;
	logic signed [ACW-1:0] ext_q [2][2];  // box, x/y
	logic        hit_q;

	obot_pkg::mul_ctl_t    mctl;
	logic signed [OW-1:0]  ma;
	logic signed [OW-1:0]  mb;
	logic                  mdone;
	logic signed [ACW-1:0] mprod;

	obot_serial_mul #(.AW(OW), .BW(OW)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb),
		.done(mdone), .prod(mprod)
	);

	// Axis under test: 0/1 held u/v, 2/3 new u/v; the other box is 1-own.
	logic                   own;
	logic signed [AXW-1:0]  tax, tay;
	logic [COORD_WIDTH-2:0] town_h;
	always_comb begin
		own    = axis_q[1];
		tax    = ax_q[own][{axis_q[0], 1'b0}];
		tay    = ax_q[own][{axis_q[0], 1'b1}];
		town_h = h_q[own][axis_q[0]];
	end

	function automatic logic signed [ACW-1:0] absv(input logic signed [ACW-1:0] v);
		absv = v[ACW-1] ? -v : v;
	endfunction

	// Operand select per step.
	// Axis steps: 0 dx*ax 1 dy*ay 2 ax*oux 3 ay*ouy 4 cu*ohu 5 ax*ovx 6 ay*ovy 7 cv*ohv
	// Bound steps (axis_q = box): 0 |ux|*hu 1 |vx|*hv 2 |uy|*hu 3 |vy|*hv
	// One extra bit so the magnitude of the most negative axis value fits.
	logic signed [AXW:0]   abs_ax;
	logic signed [ACW-1:0] cosv;
	always_comb begin
		ma     = '0;
		mb     = '0;
		abs_ax = '0;
		cosv   = absv(dot_q) >>> AXIS_FRAC_BITS;
		if (state_q == ST_BND) begin
			abs_ax = (AXW+1)'(ax_q[axis_q[0]][{step_q[0], step_q[1]}]);
			abs_ax = abs_ax[AXW] ? -abs_ax : abs_ax;
			ma = OW'(abs_ax);
			mb = OW'({1'b0, h_q[axis_q[0]][step_q[0]]});
		end else begin
			case (step_q)
				4'd0: begin ma = dx_q; mb = OW'(tax); end
				4'd1: begin ma = dy_q; mb = OW'(tay); end
				4'd2: begin ma = OW'(tax); mb = OW'(ax_q[~own][0]); end
				4'd3: begin ma = OW'(tay); mb = OW'(ax_q[~own][1]); end
				4'd4: begin ma = OW'(cosv); mb = OW'({1'b0, h_q[~own][0]}); end
				4'd5: begin ma = OW'(tax); mb = OW'(ax_q[~own][2]); end
				4'd6: begin ma = OW'(tay); mb = OW'(ax_q[~own][3]); end
				4'd7: begin ma = OW'(cosv); mb = OW'({1'b0, h_q[~own][1]}); end
				default: begin ma = '0; mb = '0; end
			endcase
		end
	end

	// Midpoint of one axis with floor and saturation.
	function automatic logic [COORD_WIDTH-1:0] mid(
		input logic signed [ACW-1:0] ca, input logic signed [ACW-1:0] ea,
		input logic signed [ACW-1:0] cb, input logic signed [ACW-1:0] eb);
		logic signed [ACW-1:0] lo, hi, s, q, top, bot;
		lo  = ((ca - ea) > (cb - eb)) ? (ca - ea) : (cb - eb);
		hi  = ((ca + ea) < (cb + eb)) ? (ca + ea) : (cb + eb);
		s   = lo + hi;
		q   = s >>> 1;
		top = ACW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
		bot = -top - 1;
		if (q > top) q = top;
		if (q < bot) q = bot;
		mid = q[COORD_WIDTH-1:0];
	endfunction

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			mctl.start <= 1'b0;
			for (int k = 0; k < 2; k++) begin
				c_q[0][k] <= '0;
				h_q[0][k] <= '0;
			end
			for (int k = 0; k < 4; k++) ax_q[0][k] <= '0;
		end else begin
			mctl.start <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (!second) begin
							c_q[0][0] <= cx; c_q[0][1] <= cy;
							ax_q[0][0] <= ux; ax_q[0][1] <= uy;
							ax_q[0][2] <= vx; ax_q[0][3] <= vy;
							h_q[0][0] <= hu; h_q[0][1] <= hv;
						end else begin
							c_q[1][0] <= cx; c_q[1][1] <= cy;
							ax_q[1][0] <= ux; ax_q[1][1] <= uy;
							ax_q[1][2] <= vx; ax_q[1][3] <= vy;
							h_q[1][0] <= hu; h_q[1][1] <= hv;
							axis_q  <= '0;
							step_q  <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					dx_q   <= OW'(c_q[0][0]) - OW'(c_q[1][0]);
					dy_q   <= OW'(c_q[0][1]) - OW'(c_q[1][1]);
					cen_q  <= '0;
					dot_q  <= '0;
					proj_q <= ACW'({1'b0, town_h}) <<< AXIS_FRAC_BITS;
					mctl.start <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mdone) begin
						case (step_q)
							4'd0, 4'd1: cen_q <= cen_q + mprod;
							4'd2, 4'd5: dot_q <= mprod;
							4'd3, 4'd6: dot_q <= dot_q + mprod;
							default:    proj_q <= proj_q + mprod;
						endcase
						if (step_q == 4'd7) begin
							state_q <= ST_AXEND;
						end else begin
							step_q <= step_q + 1'b1;
							mctl.start <= 1'b1;
						end
					end
				end
				ST_AXEND: begin
					step_q <= '0;
					if (absv(cen_q) > proj_q) begin
						hit_q   <= 1'b0;
						hit_x   <= '0;
						hit_y   <= '0;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (axis_q == 2'd3) begin
						axis_q  <= '0;
						mctl.start <= 1'b1;
						state_q <= ST_BND;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_BND: begin
					if (mdone) begin
						if (step_q[0] == 1'b0)
							ext_q[axis_q[0]][step_q[1]] <= mprod;
						else
							ext_q[axis_q[0]][step_q[1]] <=
								(ext_q[axis_q[0]][step_q[1]] + mprod) >>> AXIS_FRAC_BITS;
						if (step_q == 4'd3) begin
							state_q <= ST_BNDEND;
						end else begin
							step_q <= step_q + 1'b1;
							mctl.start <= 1'b1;
						end
					end
				end
				ST_BNDEND: begin
					step_q <= '0;
					if (axis_q[0]) begin
						state_q <= ST_MID;
					end else begin
						axis_q  <= 2'd1;
						mctl.start <= 1'b1;
						state_q <= ST_BND;
					end
				end
				ST_MID: begin
					hit_q <= 1'b1;
					hit_x <= mid(ACW'(c_q[0][0]), ext_q[0][0], ACW'(c_q[1][0]), ext_q[1][0]);
					hit_y <= mid(ACW'(c_q[0][1]), ext_q[0][1], ACW'(c_q[1][1]), ext_q[1][1]);
					out_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign hit = hit_q;
endmodule
`default_nettype wire

>>> design/obot_checker.sv
// ----------------------------------------------------------------------------
// obot_checker
// Port-level checks of the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "oriented_box_overlap_test_macros.svh"
module obot_checker #(
	parameter int ODW = 56
) (
	input wire           clk,
	input wire           arst_n,
	input wire           s_axis_tvalid,
	input wire           s_axis_tready,
	input wire           s_axis_tuser,
	input wire           m_axis_tvalid,
	input wire           m_axis_tready,
	input wire [ODW-1:0] m_axis_tdata
);
	`OBOT_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`OBOT_ASSERT_IMP(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[ODW-1:1] == '0)
	`OBOT_ASSERT_IMP(a_busy, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`OBOT_ASSERT_NXT(a_test_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)
endmodule

bind oriented_box_overlap_test obot_checker #(.ODW(ODW)) u_obot_checker (.*);
`default_nettype wire

>>> tb/tb_oriented_box_overlap_test.sv
// ----------------------------------------------------------------------------
// tb_oriented_box_overlap_test
// Self-checking bench for the oriented box overlap test.
// ----------------------------------------------------------------------------
// A queue of boxes (store and test items) feeds a stream driver. Each
// accepted item runs through a local separating-axis predictor. The predictor
// keeps its own held box, and every test item queues one expected result. A
// monitor compares each result item field by field. Random idle bursts sit on
// both sides, except near the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_oriented_box_overlap_test;
	localparam int CW   = obot_pkg::COORD_WIDTH_DEF;
	localparam int AFB  = obot_pkg::AXIS_FRAC_BITS_DEF;
	localparam int AXW  = AFB + 2;
	localparam int HW   = CW - 1;
	localparam int IDW  = 160;
	localparam int ODW  = 56;
	localparam int N_RANDOM = 1620;
	localparam int QUIET_TAIL = 150;
	localparam int DRAIN_CYCLES = 1200;

	typedef struct {
		logic signed [CW-1:0]  cx, cy;
		logic signed [AXW-1:0] ux, uy, vx, vy;
		logic [HW-1:0]         hu, hv;
		logic                  second_box;
	} box_t;

	typedef struct {
		logic                 hit;
		logic signed [CW-1:0] hx, hy;
	} hit_t;

	logic           clk;
	logic           arst_n;
	logic           s_axis_tvalid;
	logic           s_axis_tready;
	// center_x, center_y, axis_u_x, axis_u_y, axis_v_x, axis_v_y, half_u, half_v
	logic [IDW-1:0] s_axis_tdata;
	// second_box
	logic           s_axis_tuser;
	logic           m_axis_tvalid;
	logic           m_axis_tready;
	// hit, hit_x, hit_y
	logic [ODW-1:0] m_axis_tdata;

	box_t pending_boxes[$];
	hit_t expected_hits[$];
	box_t held_box;
	box_t cur_box;
	int   n_errors = 0;
	int   n_tests = 0;
	int   n_hits = 0;
	int   n_stores = 0;
	bit   in_taken;
	bit   quiet;
	int   send_gap;
	int   recv_gap;

	oriented_box_overlap_test i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint iabs(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// True when axis (ax, ay) with own half size h leaves the boxes overlapping.
	function automatic bit axis_holds(longint dx, longint dy, longint ax, longint ay,
			longint h, box_t o);
		longint cen, cu, cv, proj;
		cen  = iabs(dx * ax + dy * ay);
		cu   = iabs(ax * longint'(o.ux) + ay * longint'(o.uy)) >> AFB;
		cv   = iabs(ax * longint'(o.vx) + ay * longint'(o.vy)) >> AFB;
		proj = cu * longint'(o.hu) + cv * longint'(o.hv) + (h << AFB);
		return cen <= proj;
	endfunction

	function automatic longint extent_of(logic signed [AXW-1:0] a, logic signed [AXW-1:0] b,
			box_t bx);
		return (iabs(longint'(a)) * longint'(bx.hu) + iabs(longint'(b)) * longint'(bx.hv))
			>>> AFB;
	endfunction

	function automatic logic signed [CW-1:0] midpoint(longint lo, longint hi);
		longint q;
		longint top;
		top = (longint'(1) << (CW - 1)) - 1;
		q = (lo + hi) >>> 1;
		if (q > top)
			q = top;
		if (q < -top - 1)
			q = -top - 1;
		return q[CW-1:0];
	endfunction

	function automatic hit_t overlap_test(box_t s, box_t d);
		hit_t   r;
		longint dx, dy, sex, sey, dex, dey;
		r = '{hit: 1'b0, hx: '0, hy: '0};
		dx = longint'(s.cx) - longint'(d.cx);
		dy = longint'(s.cy) - longint'(d.cy);
		if (!axis_holds(dx, dy, s.ux, s.uy, s.hu, d) || !axis_holds(dx, dy, s.vx, s.vy, s.hv, d)
				|| !axis_holds(dx, dy, d.ux, d.uy, d.hu, s)
				|| !axis_holds(dx, dy, d.vx, d.vy, d.hv, s))
			return r;
		sex = extent_of(s.ux, s.vx, s);
		sey = extent_of(s.uy, s.vy, s);
		dex = extent_of(d.ux, d.vx, d);
		dey = extent_of(d.uy, d.vy, d);
		r.hit = 1'b1;
		// intersect the two bounding rectangles: max of mins, min of maxes
		r.hx = midpoint((s.cx - sex > d.cx - dex) ? s.cx - sex : d.cx - dex,
			(s.cx + sex < d.cx + dex) ? s.cx + sex : d.cx + dex);
		r.hy = midpoint((s.cy - sey > d.cy - dey) ? s.cy - sey : d.cy - dey,
			(s.cy + sey < d.cy + dey) ? s.cy + sey : d.cy + dey);
		return r;
	endfunction

	function automatic box_t make_box(int cx, int cy, int ux, int uy, int vx, int vy,
			int hu, int hv, bit sb);
		box_t b;
		b.cx = CW'(cx);
		b.cy = CW'(cy);
		b.ux = AXW'(ux);
		b.uy = AXW'(uy);
		b.vx = AXW'(vx);
		b.vy = AXW'(vy);
		b.hu = HW'(hu);
		b.hv = HW'(hv);
		b.second_box = sb;
		return b;
	endfunction

	function automatic int rand_axis();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic box_t rand_noise_box();
		return make_box(int'($urandom), int'($urandom), rand_axis(), rand_axis(), rand_axis(),
			rand_axis(), int'($urandom), int'($urandom), bit'($urandom_range(0, 1)));
	endfunction

	// Near-unit rotated frame around a given center, small sizes for frequent overlap.
	function automatic box_t rand_frame_box(int cx, int cy, bit sb);
		int c, s, k;
		int cosv[8] = '{16384, 15137, 11585, 6270, 0, -6270, -11585, -15137};
		int sinv[8] = '{0, 6270, 11585, 15137, 16384, 15137, 11585, 6270};
		k = int'($urandom_range(0, 7));
		c = cosv[k];
		s = sinv[k];
		if ($urandom_range(0, 1)) begin
			c = -c;
			s = -s;
		end
		return make_box(cx, cy, c, s, -s, c, int'($urandom_range(0, 1 << 14)),
			int'($urandom_range(0, 1 << 14)), sb);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// Driver: inputs move on the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (in_taken || !s_axis_tvalid) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 8);
					s_axis_tvalid <= 1'b0;
				end else if (pending_boxes.size() > 0) begin
					cur_box = pending_boxes.pop_front();
					s_axis_tdata <= {2'b00, cur_box.hv, cur_box.hu, cur_box.vy, cur_box.vx,
						cur_box.uy, cur_box.ux, cur_box.cy, cur_box.cx};
					s_axis_tuser <= cur_box.second_box;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 8);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor: inputs and outputs are sampled on the rising edge.
	always @(posedge clk) begin
		hit_t got, want;
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (cur_box.second_box) begin
					expected_hits.push_back(overlap_test(held_box, cur_box));
					n_tests++;
				end else begin
					held_box = cur_box;
					n_stores++;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit = m_axis_tdata[0];
				got.hx  = m_axis_tdata[CW:1];
				got.hy  = m_axis_tdata[2*CW:CW+1];
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected result, hit", got.hit, 0);
				end else begin
					want = expected_hits.pop_front();
					if (want.hit)
						n_hits++;
					if (got.hit !== want.hit)
						report_mismatch("hit", got.hit, want.hit);
					if (got.hx !== want.hx)
						report_mismatch("hit_x", got.hx, want.hx);
					if (got.hy !== want.hy)
						report_mismatch("hit_y", got.hy, want.hy);
				end
			end
		end
	end

	initial begin
		int cx, cy, n;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		held_box = make_box(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		in_taken = 1'b0;
		quiet = 1'b0;
		send_gap = 0;
		recv_gap = 0;

		// test against the all-zero held box before any store
		pending_boxes.push_back(make_box(0, 0, 16384, 0, 0, 16384, 256, 256, 1'b1));
		pending_boxes.push_back(make_box(5000, -3000, 16384, 0, 0, 16384, 256, 256, 1'b1));
		pending_boxes.push_back(make_box(0, 0, 16384, 0, 0, 16384, 1024, 512, 1'b0));
		pending_boxes.push_back(make_box(0, 0, 16384, 0, 0, 16384, 1024, 512, 1'b1));
		pending_boxes.push_back(make_box(100000, 0, 16384, 0, 0, 16384, 1024, 512, 1'b1));
		// edges exactly touching: equality counts as overlap
		pending_boxes.push_back(make_box(2048, 0, 16384, 0, 0, 16384, 1024, 512, 1'b1));
		pending_boxes.push_back(make_box(2049, 0, 16384, 0, 0, 16384, 1024, 512, 1'b1));
		// 45 degree box against the axis-aligned one
		pending_boxes.push_back(make_box(1500, 1500, 11585, 11585, -11585, 11585, 700, 300, 1'b1));
		// negative full-scale axes, zero sizes
		pending_boxes.push_back(make_box(0, 0, -16384, 0, 0, -16384, 0, 0, 1'b1));
		// axes that are not unit length
		pending_boxes.push_back(make_box(300, -200, 16384, 16384, -16384, 16384, 900, 900, 1'b1));
		// extreme corners with maximum sizes: saturated hit point
		pending_boxes.push_back(make_box(8388607, 8388607, 16384, 16384, -16384, 16384,
			8388607, 8388607, 1'b0));
		pending_boxes.push_back(make_box(-8388608, -8388608, -16384, -16384, 16384, -16384,
			8388607, 8388607, 1'b1));
		pending_boxes.push_back(make_box(8388607, -8388608, -1, 1, 16383, -16383,
			8388607, 8388607, 1'b1));
		pending_boxes.push_back(make_box(-8388608, 8388607, 16384, 0, 0, 16384, 0, 0, 1'b1));
		pending_boxes.push_back(make_box(-8388608, 8388607, 0, -16384, 16384, 0,
			4194304, 1, 1'b0));
		pending_boxes.push_back(make_box(-8388608, 8388607, 16384, 0, 0, 16384, 2, 4194303, 1'b1));
		pending_boxes.push_back(make_box(8388607, 8388607, 16384, 0, 0, 16384, 0, 0, 1'b1));

		n = 0;
		while (n < N_RANDOM) begin
			if ($urandom_range(0, 4) == 0) begin
				pending_boxes.push_back(rand_noise_box());
				n++;
			end else begin
				cx = int'($urandom_range(0, 1 << 22)) - (1 << 21);
				cy = int'($urandom_range(0, 1 << 22)) - (1 << 21);
				pending_boxes.push_back(rand_frame_box(cx, cy, 1'b0));
				n++;
				repeat ($urandom_range(1, 3)) begin
					pending_boxes.push_back(rand_frame_box(
						cx + int'($urandom_range(0, 1 << 16)) - (1 << 15),
						cy + int'($urandom_range(0, 1 << 16)) - (1 << 15), 1'b1));
					n++;
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_boxes.size() < QUIET_TAIL);
		quiet = 1'b1;
		wait (pending_boxes.size() == 0 && !s_axis_tvalid);
		wait (expected_hits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_hits.size() != 0) begin
			$display("%0d results never arrived", expected_hits.size());
			n_errors++;
		end
		$display("covered %0d stores and %0d tests (%0d overlaps) with idle bursts",
			n_stores, n_tests, n_hits);
		if (n_errors == 0)
			$display("[oriented_box_overlap_test] OK");
		else
			$display("[oriented_box_overlap_test] ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout");
		$display("[oriented_box_overlap_test] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
